### rtl/core/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared constants and types of the region box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int MAX_RADIUS  = 8;
    localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(STORE_ROWS);
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
    localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int RAD_BITS    = 4;
    localparam int CFG_BITS    = 12;
    localparam int HGT_BITS    = $clog2(MAX_HEIGHT);
    localparam int SUM_BITS    = $clog2(STORE_ROWS * STORE_ROWS * 255 + 1);
    localparam int N_BITS      = $clog2(STORE_ROWS * STORE_ROWS + 1);
    localparam int POS_BITS    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int TOT_BITS    = POS_BITS + 1;

    localparam logic [1:0] CFG_REGION_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_REGION_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BLUR_RADIUS   = 2'd2;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          data;
    } t_store_wr;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] sum_r;
        logic [SUM_BITS-1:0] sum_g;
        logic [SUM_BITS-1:0] sum_b;
        logic [N_BITS-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] q_r;
        logic [7:0] q_g;
        logic [7:0] q_b;
    } t_div_rsp;

endpackage

### rtl/core/bbr_if.sv
// ----------------------------------------------------------------------------
// bbr_if
// Valid/ready channels for the pixel input and the result output.
// ----------------------------------------------------------------------------
interface bbr_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] in_pixel;

    modport source (output valid, output mode, output in_pixel, input ready);
    modport sink   (input valid, input mode, input in_pixel, output ready);
endinterface

interface bbr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic        frame_end;

    modport source (output valid, output out_pixel, output frame_end, input ready);
    modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

### rtl/core/box_blur_region.sv
// ----------------------------------------------------------------------------
// box_blur_region
// Box blur over a rectangular region streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels go into a ring of 17 source rows held in one memory. A pixel item
// is taken only while the block is idle; when it completes the window of the
// next pending result, the block reads that window from the line store one
// pixel per cycle ((2r+1)^2 reads), then divides the three channel sums in a
// bit-serial divider (17 steps). Results are r rows plus r pixels behind
// their pixel; drain items (mode 1) push out edge pixels that have already
// arrived. A write to any of the three configuration registers restarts the
// frame. No clearing pass is needed.
module box_blur_region
    import bbr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    bbr_in_if.sink              i_in,
    bbr_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EDGE  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // configuration and derived values
    logic [CFG_BITS-1:0] r_cfg_w, r_cfg_h;
    logic [RAD_BITS-1:0] r_cfg_r;
    logic [CFG_BITS-1:0] r_w, r_h;
    logic [RAD_BITS-1:0] r_rad;
    logic [TOT_BITS-1:0] r_total;
    logic [TOT_BITS-1:0] r_lag;
    logic [N_BITS-1:0]   r_n;
    logic [CFG_BITS-1:0] w_w, w_h;
    logic [RAD_BITS-1:0] w_rad;
    logic [N_BITS-1:0]   w_span;

    // positions
    logic [2:0]          r_state;
    logic                r_full;
    logic [COL_BITS-1:0] r_in_col;
    logic [HGT_BITS-1:0] r_in_row;
    logic [ROW_BITS-1:0] r_in_rmod;
    logic [POS_BITS-1:0] r_in_idx;
    logic [POS_BITS-1:0] r_out_pos;
    logic [COL_BITS-1:0] r_pcol;
    logic [HGT_BITS-1:0] r_prow;
    logic [ROW_BITS-1:0] r_pmod;

    // window walk
    logic [ROW_BITS-1:0] r_wrow;
    logic [COL_BITS-1:0] r_wcol, r_cbase;
    logic [ROW_BITS-1:0] r_wx, r_wy;
    logic                r_rd_vld;
    logic [SUM_BITS-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic                r_div_go;
    logic [31:0]         r_res;
    logic                r_res_end;

    logic                r_out_vld;
    logic [31:0]         r_out_pix;
    logic                r_out_end;

    logic                w_acc;
    logic                w_edge;
    logic [CFG_BITS-1:0] w_prow12, w_pcol12, w_rad12;
    logic [TOT_BITS-1:0] w_out_ext, w_rcvd;
    logic                w_hit;
    logic                w_last_out;
    logic [ROW_BITS-1:0] w_rstart;
    logic [ROW_BITS-1:0] w_span2;
    logic                w_re;
    logic [ADDR_BITS-1:0] w_raddr;
    logic [31:0]         w_rdata;
    t_store_wr           w_wr;
    t_div_req            w_dreq;
    t_div_rsp            w_drsp;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_w = CFG_BITS'(1);
        end else if (r_cfg_w > CFG_BITS'(MAX_WIDTH)) begin
            w_w = CFG_BITS'(MAX_WIDTH);
        end else begin
            w_w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            w_h = CFG_BITS'(1);
        end else if (r_cfg_h > CFG_BITS'(MAX_HEIGHT)) begin
            w_h = CFG_BITS'(MAX_HEIGHT);
        end else begin
            w_h = r_cfg_h;
        end
        w_rad  = (r_cfg_r > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : r_cfg_r;
        w_span = {{(N_BITS - RAD_BITS - 1){1'b0}}, w_rad, 1'b1};
    end

    // derived values are registered from the configuration registers
    always_ff @(posedge i_clk) begin
        r_w     <= w_w;
        r_h     <= w_h;
        r_rad   <= w_rad;
        r_total <= TOT_BITS'(w_w) * TOT_BITS'(w_h);
        r_lag   <= TOT_BITS'(w_rad) * TOT_BITS'(w_w) + TOT_BITS'(w_rad);
        r_n     <= N_BITS'(w_span * w_span);
    end

    assign w_acc      = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign w_prow12 = CFG_BITS'(r_prow);
    assign w_pcol12 = CFG_BITS'(r_pcol);
    assign w_rad12  = CFG_BITS'(r_rad);
    assign w_edge   = (w_prow12 < w_rad12) || (w_prow12 + w_rad12 >= r_h) ||
                      (w_pcol12 < w_rad12) || (w_pcol12 + w_rad12 >= r_w);

    assign w_out_ext  = TOT_BITS'(r_out_pos);
    assign w_rcvd     = r_full ? r_total : TOT_BITS'(r_in_idx);
    assign w_last_out = (w_out_ext + 1'b1 >= r_total);
    assign w_span2    = {r_rad, 1'b0};
    assign w_rstart   = (r_pmod >= ROW_BITS'(r_rad)) ? r_pmod - ROW_BITS'(r_rad)
                                                     : r_pmod + ROW_BITS'(STORE_ROWS)
                                                       - ROW_BITS'(r_rad);

    always_comb begin
        w_hit = 1'b0;
        if (!i_in.mode) begin
            w_hit = !r_full && (w_out_ext < r_total) &&
                    (TOT_BITS'(r_in_idx) >= w_out_ext + r_lag);
        end else begin
            w_hit = (w_out_ext < w_rcvd) && (w_out_ext < r_total) && w_edge;
        end
    end

    assign w_wr.we   = w_acc && !i_in.mode && !r_full;
    assign w_wr.addr = {r_in_rmod, r_in_col};
    assign w_wr.data = i_in.in_pixel;

    assign w_re    = ((r_state == S_START) && w_edge) || (r_state == S_SUM);
    assign w_raddr = (r_state == S_SUM) ? {r_wrow, r_wcol} : {r_pmod, r_pcol};

    assign w_dreq.start   = r_div_go;
    assign w_dreq.sum_r   = r_sum_r;
    assign w_dreq.sum_g   = r_sum_g;
    assign w_dreq.sum_b   = r_sum_b;
    assign w_dreq.divisor = r_n;

    bbr_store u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bbr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= CFG_BITS'(1920);
            r_cfg_h   <= CFG_BITS'(1080);
            r_cfg_r   <= RAD_BITS'(8);
            r_state   <= S_IDLE;
            r_full    <= 1'b0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_rmod <= '0;
            r_in_idx  <= '0;
            r_out_pos <= '0;
            r_pcol    <= '0;
            r_prow    <= '0;
            r_pmod    <= '0;
            r_rd_vld  <= 1'b0;
            r_div_go  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SUM);
            r_div_go <= 1'b0;
            // drop the beat once taken, unless a new one loads this cycle
            if (o_out.ready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == CFG_REGION_WIDTH ||
                             i_cfg_index == CFG_REGION_HEIGHT ||
                             i_cfg_index == CFG_BLUR_RADIUS)) begin
                case (i_cfg_index)
                    CFG_REGION_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_REGION_HEIGHT: r_cfg_h <= i_cfg_data;
                    CFG_BLUR_RADIUS:   r_cfg_r <= i_cfg_data[RAD_BITS-1:0];
                    default:           r_cfg_r <= r_cfg_r;
                endcase
                r_full    <= 1'b0;
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_in_rmod <= '0;
                r_in_idx  <= '0;
                r_out_pos <= '0;
                r_pcol    <= '0;
                r_prow    <= '0;
                r_pmod    <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (w_wr.we) begin
                            // advance the input position
                            if (CFG_BITS'(r_in_col) + 1'b1 >= r_w) begin
                                r_in_col <= '0;
                                if (CFG_BITS'(r_in_row) + 1'b1 >= r_h) begin
                                    r_in_row  <= '0;
                                    r_in_rmod <= '0;
                                    r_in_idx  <= '0;
                                    r_full    <= 1'b1;
                                end else begin
                                    r_in_row  <= r_in_row + 1'b1;
                                    r_in_rmod <= (r_in_rmod == ROW_BITS'(STORE_ROWS - 1))
                                                 ? '0 : r_in_rmod + 1'b1;
                                    r_in_idx  <= r_in_idx + 1'b1;
                                end
                            end else begin
                                r_in_col <= r_in_col + 1'b1;
                                r_in_idx <= r_in_idx + 1'b1;
                            end
                        end
                        if (w_hit) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_res_end <= w_last_out;
                    if (w_edge) begin
                        r_state <= S_EDGE;
                    end else begin
                        r_wrow  <= w_rstart;
                        r_cbase <= r_pcol - COL_BITS'(r_rad);
                        r_wcol  <= r_pcol - COL_BITS'(r_rad);
                        r_wx    <= '0;
                        r_wy    <= '0;
                        r_sum_r <= '0;
                        r_sum_g <= '0;
                        r_sum_b <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_wx == w_span2) begin
                        r_wx   <= '0;
                        r_wy   <= r_wy + 1'b1;
                        r_wcol <= r_cbase;
                        r_wrow <= (r_wrow == ROW_BITS'(STORE_ROWS - 1)) ? '0 : r_wrow + 1'b1;
                        if (r_wy == w_span2) begin
                            r_state <= S_FLUSH;
                        end
                    end else begin
                        r_wx   <= r_wx + 1'b1;
                        r_wcol <= r_wcol + 1'b1;
                    end
                end
                S_FLUSH: begin
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_res   <= {8'h00, w_drsp.q_r, w_drsp.q_g, w_drsp.q_b};
                        r_state <= S_OUT;
                    end
                end
                S_EDGE: begin
                    r_res   <= w_rdata;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_vld || o_out.ready) begin
                        r_out_vld <= 1'b1;
                        r_out_pix <= r_res;
                        r_out_end <= r_res_end;
                        r_state   <= S_IDLE;
                        // advance the output position
                        if (r_res_end) begin
                            r_out_pos <= '0;
                            r_pcol    <= '0;
                            r_prow    <= '0;
                            r_pmod    <= '0;
                            r_full    <= 1'b0;
                        end else begin
                            r_out_pos <= r_out_pos + 1'b1;
                            if (CFG_BITS'(r_pcol) + 1'b1 >= r_w) begin
                                r_pcol <= '0;
                                r_prow <= r_prow + 1'b1;
                                r_pmod <= (r_pmod == ROW_BITS'(STORE_ROWS - 1))
                                          ? '0 : r_pmod + 1'b1;
                            end else begin
                                r_pcol <= r_pcol + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_rd_vld) begin
                r_sum_r <= r_sum_r + SUM_BITS'(w_rdata[23:16]);
                r_sum_g <= r_sum_g + SUM_BITS'(w_rdata[15:8]);
                r_sum_b <= r_sum_b + SUM_BITS'(w_rdata[7:0]);
            end
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_pixel = r_out_pix;
    assign o_out.frame_end = r_out_end;

endmodule

### rtl/core/bbr_store.sv
// ----------------------------------------------------------------------------
// bbr_store
// Line store: ring of source rows, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbr_store
    import bbr_pkg::*;
(
    input  logic                 i_clk,
    input  t_store_wr            i_wr,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [31:0]          o_rdata
);

    logic [31:0] r_mem [0:STORE_DEPTH-1];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bbr_divider.sv
// ----------------------------------------------------------------------------
// bbr_divider
// Restoring divider, one quotient bit per cycle, three channels side by side.
// ----------------------------------------------------------------------------
module bbr_divider
    import bbr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_done, n_done;
    logic [SUM_BITS-1:0] r_dvd [3];
    logic [SUM_BITS-1:0] n_dvd [3];
    logic [SUM_BITS:0]   r_rem [3];
    logic [SUM_BITS:0]   n_rem [3];
    logic [SUM_BITS-1:0] r_quo [3];
    logic [SUM_BITS-1:0] n_quo [3];
    logic [N_BITS-1:0]   r_div;
    logic [SUM_BITS:0]   w_trial [3];
    logic [SUM_BITS:0]   w_dext;

    assign w_dext = {{(SUM_BITS + 1 - N_BITS){1'b0}}, r_div};

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_trial[k] = {r_rem[k][SUM_BITS-1:0], r_dvd[k][SUM_BITS-1]};
            n_dvd[k]   = r_dvd[k];
            n_rem[k]   = r_rem[k];
            n_quo[k]   = r_quo[k];
        end
        if (i_req.start) begin
            n_cnt    = CNT_BITS'(SUM_BITS);
            n_dvd[0] = i_req.sum_r;
            n_dvd[1] = i_req.sum_g;
            n_dvd[2] = i_req.sum_b;
            for (int k = 0; k < 3; k++) begin
                n_rem[k] = '0;
                n_quo[k] = '0;
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            for (int k = 0; k < 3; k++) begin
                n_dvd[k] = {r_dvd[k][SUM_BITS-2:0], 1'b0};
                if (w_trial[k] >= w_dext) begin
                    n_rem[k] = w_trial[k] - w_dext;
                    n_quo[k] = {r_quo[k][SUM_BITS-2:0], 1'b1};
                end else begin
                    n_rem[k] = w_trial[k];
                    n_quo[k] = {r_quo[k][SUM_BITS-2:0], 1'b0};
                end
            end
            n_done = (r_cnt == CNT_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
        end
        for (int k = 0; k < 3; k++) begin
            r_dvd[k] <= n_dvd[k];
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q_r  = r_quo[0][7:0];
    assign o_rsp.q_g  = r_quo[1][7:0];
    assign o_rsp.q_b  = r_quo[2][7:0];

endmodule

### rtl/core/bbr_checker.sv
// ----------------------------------------------------------------------------
// bbr_checker
// Port-level checks of the region box blur, bound to the top level.
// ----------------------------------------------------------------------------
module bbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_pixel,
    input logic        i_out_frame_end
);

    // hold an offered result beat until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel) && $stable(i_out_frame_end))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // a new result is loaded only while the input side is held off
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_out_valid) && i_out_valid && $past(i_rst_n) |-> !$past(i_in_ready))
        else $error("result appeared while input was open");

endmodule

bind box_blur_region bbr_checker u_bbr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_pixel     (o_out.out_pixel),
    .i_out_frame_end (o_out.frame_end)
);

### sim/tb_box_blur_region.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_region
// Self-checking bench for the region box blur. A directed table covers reset
// defaults, ignored pixels after a full region, drains and saturated register
// values; random regions follow, checked beat by beat against a behavioral
// predictor of the blur with its own line store and frame position.
// ----------------------------------------------------------------------------
module tb_box_blur_region;
    import bbr_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int CYCLE_CAP  = 4000000;
    localparam int SETTLE     = 400;
    localparam int ITEM_GOAL  = 1250;
    localparam int HOLD_LEN   = 3000;

    // index past the last register, written to check that it is ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ROW_BEAT, ROW_CFG, ROW_FLUSH} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        mode;
        logic [31:0] pix;
        bit          typed;
        bit          has;
        logic [31:0] exp_pix;
        logic        exp_fe;
    } t_row;

    typedef struct {
        logic [31:0] pix;
        logic        fe;
    } t_blur_out;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [CFG_BITS-1:0] i_cfg_data;

    bbr_in_if  in_ch ();
    bbr_out_if out_ch ();

    box_blur_region u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [31:0] src_rows [0:STORE_DEPTH-1];
    logic [11:0] reg_width, reg_height;
    logic [3:0]  reg_radius;
    int          next_col, next_row, next_out;
    bit          region_full;

    t_blur_out   pending_px [$];

    int err_count, cycle_count, item_count, pixel_count, drain_count;
    int result_count, region_count;
    int send_idle, recv_idle, hold_req;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    function automatic int used_width();
        if (reg_width < 1) return 1;
        return (reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width);
    endfunction

    function automatic int used_height();
        if (reg_height < 1) return 1;
        return (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height);
    endfunction

    function automatic int used_radius();
        return (reg_radius > MAX_RADIUS) ? MAX_RADIUS : int'(reg_radius);
    endfunction

    function automatic logic [31:0] src_at(input int row, input int col);
        return src_rows[(row % STORE_ROWS) * MAX_WIDTH + (col % MAX_WIDTH)];
    endfunction

    function automatic bit near_border(input int row, input int col, input int w,
                                       input int h, input int r);
        return (row < r) || (row + r >= h) || (col < r) || (col + r >= w);
    endfunction

    function automatic logic [31:0] blurred_at(input int row, input int col, input int w,
                                               input int h, input int r);
        int sr, sg, sb, n;
        logic [31:0] p;
        sr = 0;
        sg = 0;
        sb = 0;
        if (near_border(row, col, w, h, r)) return src_at(row, col);
        for (int y = row - r; y <= row + r; y++) begin
            for (int x = col - r; x <= col + r; x++) begin
                p = src_at(y, x);
                sr += int'(p[23:16]);
                sg += int'(p[15:8]);
                sb += int'(p[7:0]);
            end
        end
        n = (2 * r + 1) * (2 * r + 1);
        p = '0;
        p[23:16] = 8'(sr / n);
        p[15:8]  = 8'(sg / n);
        p[7:0]   = 8'(sb / n);
        return p;
    endfunction

    function automatic void restart_region();
        next_col    = 0;
        next_row    = 0;
        next_out    = 0;
        region_full = 0;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
        case (idx)
            CFG_REGION_WIDTH:  reg_width  = val;
            CFG_REGION_HEIGHT: reg_height = val;
            CFG_BLUR_RADIUS:   reg_radius = val[3:0];
            default: return;
        endcase
        restart_region();
    endfunction

    // advance the predictor by one accepted input beat
    function automatic void blur_step(input logic mode, input logic [31:0] pix,
                                      output bit has, output t_blur_out res);
        int w, h, r, total, lag, idx, got_so_far;
        bit rdy;
        w     = used_width();
        h     = used_height();
        r     = used_radius();
        total = w * h;
        lag   = r * w + r;
        has   = 0;
        res   = '{pix: '0, fe: 1'b0};
        if (mode == 1'b0) begin
            if (region_full) return;
            idx = next_row * w + next_col;
            src_rows[(next_row % STORE_ROWS) * MAX_WIDTH + next_col] = pix;
            next_col++;
            if (next_col >= w) begin
                next_col = 0;
                next_row++;
                if (next_row >= h) begin
                    next_row    = 0;
                    region_full = 1;
                end
            end
            rdy = (next_out < total) && (idx >= next_out + lag);
        end else begin
            got_so_far = region_full ? total : next_row * w + next_col;
            rdy = 0;
            if (next_out < got_so_far && next_out < total)
                rdy = near_border(next_out / w, next_out % w, w, h, r);
        end
        if (!rdy) return;
        has     = 1;
        res.pix = blurred_at(next_out / w, next_out % w, w, h, r);
        res.fe  = (next_out + 1 >= total);
        if (next_out + 1 >= total) begin
            next_out    = 0;
            region_full = 0;
        end else begin
            next_out++;
        end
    endfunction

    task automatic send_beat(input logic mode, input logic [31:0] pix, input bit typed,
                             input bit typed_has, input t_blur_out typed_res);
        bit has;
        t_blur_out res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.mode     = mode;
        in_ch.in_pixel = pix;
        do @(posedge i_clk); while (!in_ch.ready);
        blur_step(mode, pix, has, res);
        if (typed) begin
            has = typed_has;
            res = typed_res;
        end
        if (has) pending_px.push_back(res);
        item_count++;
        if (mode) drain_count++;
        else pixel_count++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // hold until every result is out and the block has had time to finish
    task automatic wait_quiet();
        idle_input();
        wait (pending_px.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        apply_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_beat(input logic mode);
        send_beat(mode, $urandom(), 0, 0, '{pix: '0, fe: 1'b0});
    endtask

    // one random region: mostly whole frames flushed by drains, some cut short
    task automatic random_region(input bit pause_midway);
        logic [CFG_BITS-1:0] w, h;
        logic [3:0] r;
        int pick, npix, cut;
        wait_quiet();
        pick = $urandom_range(0, 19);
        w = CFG_BITS'($urandom_range(1, 24));
        h = CFG_BITS'($urandom_range(1, 20));
        r = 4'($urandom_range(0, 8));
        if (pick == 0) begin
            w = 12'hFFF;
            h = CFG_BITS'($urandom_range(1, 2));
            r = 4'hF;
        end else if (pick == 1) begin
            w = 12'd0;
            h = 12'hFFF;
            r = 4'($urandom_range(9, 15));
        end else if (pick == 2) begin
            h = 12'd0;
        end
        write_reg(CFG_REGION_WIDTH, w);
        write_reg(CFG_REGION_HEIGHT, h);
        write_reg(CFG_BLUR_RADIUS, {8'd0, r});
        npix = used_width() * used_height();
        cut  = ($urandom_range(0, 7) == 0 || npix > 600) ? $urandom_range(1, 40) : npix;
        if (cut > npix) cut = npix;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 9) == 0) random_beat(1'b1);
            if (pause_midway && i == cut / 2) begin
                idle_input();
                wait (pending_px.size() == 0);
            end
            random_beat(1'b0);
        end
        if (cut == npix) begin
            while (region_full) begin
                if ($urandom_range(0, 9) == 0) random_beat(1'b0);
                random_beat(1'b1);
            end
            region_count++;
        end
        random_beat(1'b1);
    endtask

    always @(negedge i_clk) begin : result_ready
        int hold_left;
        if (hold_req != 0) begin
            hold_left = HOLD_LEN;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_blur_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_px.size() == 0) begin
                report_mismatch("unexpected beat", out_ch.out_pixel, 32'd0);
            end else begin
                want = pending_px.pop_front();
                if (out_ch.out_pixel !== want.pix)
                    report_mismatch("out_pixel", out_ch.out_pixel, want.pix);
                if (out_ch.frame_end !== want.fe)
                    report_mismatch("frame_end", {31'd0, out_ch.frame_end}, {31'd0, want.fe});
                result_count++;
            end
        end
    end

    t_row dir_rows [$];

    function automatic void add_row(input t_row_kind k, input logic m, input logic [31:0] p,
                                    input bit t, input bit hs, input logic [31:0] ep,
                                    input logic ef);
        dir_rows.push_back('{kind: k, mode: m, pix: p, typed: t, has: hs,
                             exp_pix: ep, exp_fe: ef});
    endfunction

    initial begin
        int target;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = 1'b0;
        in_ch.in_pixel = '0;
        out_ch.ready   = 1'b0;
        send_idle      = 8;
        recv_idle      = 73;
        hold_req       = 0;
        for (int i = 0; i < STORE_DEPTH; i++) src_rows[i] = '0;
        reg_width  = 12'd1920;
        reg_height = 12'd1080;
        reg_radius = 4'd8;
        restart_region();

        // reset defaults: border pixels drain out unchanged
        add_row(ROW_BEAT, 1, 32'h0,        1, 0, 32'h0,        0);
        add_row(ROW_BEAT, 0, 32'hFFFFFFFF, 1, 0, 32'h0,        0);
        add_row(ROW_BEAT, 1, 32'hDEADBEEF, 1, 1, 32'hFFFFFFFF, 0);
        add_row(ROW_BEAT, 0, 32'h00000000, 1, 0, 32'h0,        0);
        add_row(ROW_BEAT, 1, 32'h0,        1, 1, 32'h00000000, 0);
        add_row(ROW_FLUSH, 0, 32'h0, 0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_UNUSED, 12'hFFF}, 0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_REGION_WIDTH,  12'd3}, 0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_REGION_HEIGHT, 12'd3}, 0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_BLUR_RADIUS,   12'd1}, 0, 0, 32'h0, 0);
        // 3x3 of white: one blurred center, top byte cleared
        for (int i = 0; i < 4; i++) add_row(ROW_BEAT, 0, 32'hFFFFFFFF, 1, 0, 32'h0, 0);
        for (int i = 0; i < 4; i++)
            add_row(ROW_BEAT, 0, 32'hFFFFFFFF, 1, 1, 32'hFFFFFFFF, 0);
        add_row(ROW_BEAT, 0, 32'hFFFFFFFF, 1, 1, 32'h00FFFFFF, 0);
        // region complete: the next pixel is dropped
        add_row(ROW_BEAT, 0, 32'h12345678, 1, 0, 32'h0, 0);
        for (int i = 0; i < 3; i++) add_row(ROW_BEAT, 1, 32'h0, 1, 1, 32'hFFFFFFFF, 0);
        add_row(ROW_BEAT, 1, 32'h0, 1, 1, 32'hFFFFFFFF, 1);
        add_row(ROW_FLUSH, 0, 32'h0, 0, 0, 32'h0, 0);
        // zero sizes saturate to one pixel, radius past the top saturates
        add_row(ROW_CFG, 0, {18'd0, CFG_REGION_WIDTH,  12'd0},   0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_REGION_HEIGHT, 12'd0},   0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_BLUR_RADIUS,   12'hFFF}, 0, 0, 32'h0, 0);
        // the lone pixel waits for a drain to pass it through
        add_row(ROW_BEAT, 0, 32'h12345678, 1, 0, 32'h0, 0);
        add_row(ROW_BEAT, 1, 32'h0, 1, 1, 32'h12345678, 1);
        add_row(ROW_BEAT, 0, 32'hA5A5A5A5, 0, 0, 32'h0, 0);
        add_row(ROW_FLUSH, 0, 32'h0, 0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_REGION_WIDTH,  12'hFFF}, 0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_REGION_HEIGHT, 12'd1},   0, 0, 32'h0, 0);
        add_row(ROW_CFG, 0, {18'd0, CFG_BLUR_RADIUS,   12'd0},   0, 0, 32'h0, 0);
        // radius zero still averages, so the top byte is cleared
        add_row(ROW_BEAT, 0, 32'h80000001, 1, 1, 32'h00000001, 0);
        add_row(ROW_BEAT, 0, 32'h7FFFFFFE, 0, 0, 32'h0, 0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            case (dir_rows[k].kind)
                ROW_BEAT: send_beat(dir_rows[k].mode, dir_rows[k].pix, dir_rows[k].typed,
                                    dir_rows[k].has,
                                    '{pix: dir_rows[k].exp_pix, fe: dir_rows[k].exp_fe});
                ROW_CFG:  write_reg(dir_rows[k].pix[13:12], dir_rows[k].pix[11:0]);
                default:  wait_quiet();
            endcase
        end

        target = item_count + ITEM_GOAL / 3;
        while (item_count < target) random_region(0);

        send_idle = 73;
        recv_idle = 8;
        target = item_count + ITEM_GOAL / 3;
        random_region(1);
        while (item_count < target) random_region(0);

        send_idle = 0;
        recv_idle = 0;
        target = item_count + ITEM_GOAL / 3;
        // stall the output so the block backs up onto its input
        hold_req = 1;
        while (item_count < target) random_region(0);

        idle_input();
        wait (pending_px.size() == 0);
        repeat (SETTLE) @(posedge i_clk);

        $display("ran %0d beats (%0d pixels, %0d drains) over %0d whole regions",
                 item_count, pixel_count, drain_count, region_count);
        $display("compared %0d results, %0d mismatches", result_count, err_count);
        if (err_count == 0 && pending_px.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
